/* sv/tdf_pkg.sv */
// Shared types and constants of the trial-division factorizer.
// Holds the result field widths, status codes and sequencer state type.
// Depends on nothing; the top level and the testbench files use it, tdf_div does not.
`default_nettype none

package tdf_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int PRIME_W        = 31;
  localparam int EXP_W          = 5;
  localparam int STATUS_W       = 2;
  localparam int MAX_RESULTS    = 9;

  localparam logic [STATUS_W-1:0] ST_FACTOR = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ONE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TWO,
    S_DIV_START,
    S_DIV_WAIT,
    S_REC,
    S_FINISH
  } tdf_state_t;

endpackage

`default_nettype wire

/* sv/tdf_div.sv */
// Restoring divider of the trial-division factorizer, one quotient bit a cycle.
// Depends on nothing beyond its parameter; instantiated by the top level.
`default_nettype none

module tdf_div #(
  parameter int W = 31
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quot,
  output logic [W-1:0]      rem
);

  localparam int CNT_W = $clog2(W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     quot_r, quot_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     dsr_r, dsr_nxt;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             ge;

  // The partial remainder takes in the next dividend bit, which sits at the top
  // of the quotient shift register.
  assign trial = {rem_r, quot_r[W-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quot_nxt = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quot_nxt = {quot_r[W-2:0], ge};
      rem_nxt  = ge ? diff[W-1:0] : trial[W-1:0];
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

/* sv/trial_division_factorizer.sv */
// Top level of the trial-division factorizer: sequencer, result staging, output.
// Depends on tdf_pkg and instantiates the shared divider tdf_div.
//
// Usage. The input channel (in_valid, in_stall, in_value) takes one integer per
// transaction. The result channel (out_valid, out_stall and the four fields)
// gives one transaction per distinct prime factor, in ascending order, with
// out_last set on the final one. An input of one gives a single transaction with
// status "one"; an input of zero gives a single transaction with status "zero".
// Timing. The block works on one integer at a time and holds in_stall high from
// acceptance until its final result has been loaded into the output register.
// Factors of two are removed one at a time by a right shift. Every further step is a
// division of the cofactor by an odd candidate on the shared restoring divider.
// One division is made per odd candidate up to the square root of the cofactor,
// plus one more each time a candidate divides, so a large prime costs the most
// divisions, while zero and one need no division and go straight through the
// staging register to the output register.
// Reset clears the sequencer, the staged result and the output valid; there is
// no clearing pass. When the receiver stalls, the result waits in the output
// register and a newly found factor waits in a one-deep staging register; the
// search pauses only when both are full.
`default_nettype none

module trial_division_factorizer #(
  parameter int VALUE_BITS = tdf_pkg::VALUE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [VALUE_BITS-1:0]         in_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tdf_pkg::PRIME_W-1:0]        out_factor_prime,
  output logic [tdf_pkg::EXP_W-1:0]          out_exponent,
  output logic [tdf_pkg::STATUS_W-1:0]       out_status,
  output logic                               out_last
);

  localparam int PRIME_W  = tdf_pkg::PRIME_W;
  localparam int EXP_W    = tdf_pkg::EXP_W;
  localparam int STATUS_W = tdf_pkg::STATUS_W;
  localparam int ECNT_A   = $clog2(VALUE_BITS + 1);
  // The exponent counter is wide enough for any multiplicity; the result keeps
  // only its low bits.
  localparam int ECNT_W   = (ECNT_A > EXP_W) ? ECNT_A : EXP_W;
  localparam int CNT_W    = $clog2(tdf_pkg::MAX_RESULTS + 1);

  tdf_pkg::tdf_state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0] n_r, n_nxt;
  logic [VALUE_BITS-1:0] d_r, d_nxt;
  logic [ECNT_W-1:0]     e_r, e_nxt;
  logic                  chk_r, chk_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      cnt_inc;

  // Factor on its way into the staging register.
  logic [PRIME_W-1:0]    rec_prime_r, rec_prime_nxt;
  logic [EXP_W-1:0]      rec_exp_r, rec_exp_nxt;
  logic                  rec_final_r, rec_final_nxt;

  // Staging register: the newest result, held back until it is known whether
  // it is the last one.
  logic                  pend_valid_r, pend_valid_nxt;
  logic [PRIME_W-1:0]    pend_prime_r, pend_prime_nxt;
  logic [EXP_W-1:0]      pend_exp_r, pend_exp_nxt;
  logic [STATUS_W-1:0]   pend_status_r, pend_status_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [PRIME_W-1:0]    out_prime_r, out_prime_nxt;
  logic [EXP_W-1:0]      out_exp_r, out_exp_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_free;

  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [VALUE_BITS-1:0] div_rem;

  logic [PRIME_W+VALUE_BITS-1:0] n_ext;
  logic [PRIME_W+VALUE_BITS-1:0] d_ext;

  tdf_div #(
    .W (VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (n_r),
    .divisor  (d_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Candidates and cofactors are fitted to the fixed width of the prime field.
  assign n_ext    = {{PRIME_W{1'b0}}, n_r};
  assign d_ext    = {{PRIME_W{1'b0}}, d_r};
  assign out_free = !out_valid_r || !out_stall;
  assign cnt_inc  = cnt_r + 1'b1;
  assign in_stall = (state_r != tdf_pkg::S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    n_nxt           = n_r;
    d_nxt           = d_r;
    e_nxt           = e_r;
    chk_nxt         = chk_r;
    cnt_nxt         = cnt_r;
    rec_prime_nxt   = rec_prime_r;
    rec_exp_nxt     = rec_exp_r;
    rec_final_nxt   = rec_final_r;
    pend_valid_nxt  = pend_valid_r;
    pend_prime_nxt  = pend_prime_r;
    pend_exp_nxt    = pend_exp_r;
    pend_status_nxt = pend_status_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_prime_nxt   = out_prime_r;
    out_exp_nxt     = out_exp_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;
    div_start       = 1'b0;

    case (state_r)
      tdf_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_value == '0) begin
            pend_valid_nxt  = 1'b1;
            pend_prime_nxt  = '0;
            pend_exp_nxt    = '0;
            pend_status_nxt = tdf_pkg::ST_ZERO;
            state_nxt       = tdf_pkg::S_FINISH;
          end else if (in_value == VALUE_BITS'(1)) begin
            pend_valid_nxt  = 1'b1;
            pend_prime_nxt  = '0;
            pend_exp_nxt    = '0;
            pend_status_nxt = tdf_pkg::ST_ONE;
            state_nxt       = tdf_pkg::S_FINISH;
          end else begin
            n_nxt     = in_value;
            e_nxt     = '0;
            cnt_nxt   = '0;
            state_nxt = tdf_pkg::S_TWO;
          end
        end
      end

      tdf_pkg::S_TWO: begin
        if (!n_r[0]) begin
          n_nxt = n_r >> 1;
          e_nxt = e_r + 1'b1;
        end else begin
          d_nxt   = VALUE_BITS'(3);
          e_nxt   = '0;
          chk_nxt = 1'b1;
          if (e_r != '0) begin
            rec_prime_nxt = PRIME_W'(2);
            rec_exp_nxt   = e_r[EXP_W-1:0];
            rec_final_nxt = 1'b0;
            state_nxt     = tdf_pkg::S_REC;
          end else begin
            state_nxt = tdf_pkg::S_DIV_START;
          end
        end
      end

      tdf_pkg::S_DIV_START: begin
        div_start = 1'b1;
        state_nxt = tdf_pkg::S_DIV_WAIT;
      end

      tdf_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          if (chk_r && (d_r > div_quot)) begin
            // Candidate squared exceeds the cofactor: what is left is prime.
            if (n_r > VALUE_BITS'(1)) begin
              rec_prime_nxt = n_ext[PRIME_W-1:0];
              rec_exp_nxt   = EXP_W'(1);
              rec_final_nxt = 1'b1;
              state_nxt     = tdf_pkg::S_REC;
            end else begin
              state_nxt = tdf_pkg::S_FINISH;
            end
          end else if (div_rem == '0) begin
            n_nxt     = div_quot;
            e_nxt     = e_r + 1'b1;
            chk_nxt   = 1'b0;
            state_nxt = tdf_pkg::S_DIV_START;
          end else begin
            d_nxt   = d_r + VALUE_BITS'(2);
            e_nxt   = '0;
            chk_nxt = 1'b1;
            if (e_r != '0) begin
              rec_prime_nxt = d_ext[PRIME_W-1:0];
              rec_exp_nxt   = e_r[EXP_W-1:0];
              rec_final_nxt = 1'b0;
              state_nxt     = tdf_pkg::S_REC;
            end else begin
              state_nxt = tdf_pkg::S_DIV_START;
            end
          end
        end
      end

      tdf_pkg::S_REC: begin
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt  = 1'b1;
            out_prime_nxt  = pend_prime_r;
            out_exp_nxt    = pend_exp_r;
            out_status_nxt = pend_status_r;
            out_last_nxt   = 1'b0;
          end
          pend_valid_nxt  = 1'b1;
          pend_prime_nxt  = rec_prime_r;
          pend_exp_nxt    = rec_exp_r;
          pend_status_nxt = tdf_pkg::ST_FACTOR;
          cnt_nxt         = cnt_inc;
          // Once the result limit is reached, later primes are dropped.
          if (rec_final_r || (cnt_inc == CNT_W'(tdf_pkg::MAX_RESULTS))) begin
            state_nxt = tdf_pkg::S_FINISH;
          end else begin
            state_nxt = tdf_pkg::S_DIV_START;
          end
        end
      end

      tdf_pkg::S_FINISH: begin
        if (!pend_valid_r) begin
          state_nxt = tdf_pkg::S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_prime_nxt  = pend_prime_r;
          out_exp_nxt    = pend_exp_r;
          out_status_nxt = pend_status_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = tdf_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = tdf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tdf_pkg::S_IDLE;
      chk_r        <= 1'b0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      chk_r        <= chk_nxt;
      cnt_r        <= cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    n_r           <= n_nxt;
    d_r           <= d_nxt;
    e_r           <= e_nxt;
    rec_prime_r   <= rec_prime_nxt;
    rec_exp_r     <= rec_exp_nxt;
    rec_final_r   <= rec_final_nxt;
    pend_prime_r  <= pend_prime_nxt;
    pend_exp_r    <= pend_exp_nxt;
    pend_status_r <= pend_status_nxt;
    out_prime_r   <= out_prime_nxt;
    out_exp_r     <= out_exp_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_factor_prime = out_prime_r;
  assign out_exponent     = out_exp_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

  // A new integer is only taken once the previous one has left the staging
  // register.
  a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !pend_valid_r)
    else $error("input accepted while a result is still staged");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == tdf_pkg::S_DIV_WAIT))
    else $error("divider finished outside the wait state");

  // The result count never passes its limit.
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(tdf_pkg::MAX_RESULTS))
    else $error("result count above limit");

  // Trial divisors are odd and at least three.
  a_div_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tdf_pkg::S_DIV_START) |-> (d_r[0] && (d_r >= VALUE_BITS'(3))))
    else $error("trial divisor not an odd number from three up");

endmodule

`default_nettype wire

/* tb/sv/tdf_factor_checker.sv */
// Factor scoreboard for the trial-division factorizer: watches both channels,
// works out every expected factor transaction and compares it field by field.
// Depends on tdf_pkg for the result widths, the status codes and MAX_RESULTS.
`default_nettype none

module tdf_factor_checker #(
  parameter int VALUE_BITS = tdf_pkg::VALUE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic [VALUE_BITS-1:0]         in_value,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic [tdf_pkg::PRIME_W-1:0]   out_factor_prime,
  input  wire logic [tdf_pkg::EXP_W-1:0]     out_exponent,
  input  wire logic [tdf_pkg::STATUS_W-1:0]  out_status,
  input  wire logic                          out_last,
  output int                                 mismatches,
  output int                                 pending
);
  import tdf_pkg::*;

  typedef struct packed {
    logic [PRIME_W-1:0]  prime;
    logic [EXP_W-1:0]    exponent;
    logic [STATUS_W-1:0] status;
    logic                last;
  } factor_rec_t;

  factor_rec_t factor_q[$];
  int          err_total = 0;
  int          waiting   = 0;

  assign mismatches = err_total;
  assign pending    = waiting;

  // Factorises one integer and queues its transactions in ascending order.
  task automatic predict_factors(input logic [VALUE_BITS-1:0] value);
    longint unsigned rest;
    longint unsigned cand;
    int              mult;
    factor_rec_t     found[$];
    factor_rec_t     rec;
    rest = 64'(value);
    rec  = '0;
    if (rest == 0) begin
      rec.status = ST_ZERO;
      found.push_back(rec);
    end else if (rest == 1) begin
      rec.status = ST_ONE;
      found.push_back(rec);
    end else begin
      rec.status = ST_FACTOR;
      mult = 0;
      while ((rest & 1) == 0) begin
        rest = rest >> 1;
        mult++;
      end
      if (mult > 0) begin
        rec.prime    = PRIME_W'(2);
        rec.exponent = mult[EXP_W-1:0];
        found.push_back(rec);
      end
      // Odd candidates only while the candidate squared fits in the cofactor.
      for (cand = 3; cand <= rest / cand; cand += 2) begin
        mult = 0;
        while (rest % cand == 0) begin
          rest = rest / cand;
          mult++;
        end
        if (mult > 0 && found.size() < MAX_RESULTS) begin
          rec.prime    = cand[PRIME_W-1:0];
          rec.exponent = mult[EXP_W-1:0];
          found.push_back(rec);
        end
      end
      if (rest > 1 && found.size() < MAX_RESULTS) begin
        rec.prime    = rest[PRIME_W-1:0];
        rec.exponent = EXP_W'(1);
        found.push_back(rec);
      end
    end
    for (int k = 0; k < found.size(); k++) begin
      rec      = found[k];
      rec.last = (k == found.size() - 1);
      factor_q.push_back(rec);
    end
  endtask

  always @(posedge clk) begin : watch
    int          bad;
    factor_rec_t want;
    bad = 0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (factor_q.size() == 0) begin
          $error("unexpected result: factor_prime %0d exponent %0d status %0d last %0d",
                 out_factor_prime, out_exponent, out_status, out_last);
          bad++;
        end else begin
          want = factor_q.pop_front();
          if (out_factor_prime !== want.prime) begin
            $error("factor_prime: expected %0d, got %0d", want.prime, out_factor_prime);
            bad++;
          end
          if (out_exponent !== want.exponent) begin
            $error("exponent: expected %0d, got %0d", want.exponent, out_exponent);
            bad++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            bad++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            bad++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_factors(in_value);
      end
    end
    err_total <= err_total + bad;
    waiting   <= factor_q.size();
  end

endmodule

`default_nettype wire

/* tb/sv/trial_division_factorizer_test.sv */
// Top of the trial-division factorizer testbench: clock, reset, stimulus and verdict.
// Depends on tdf_pkg, the block trial_division_factorizer and tdf_factor_checker.
`default_nettype none

module trial_division_factorizer_test;
  import tdf_pkg::*;

  localparam int VALUE_BITS = VALUE_BITS_DEF;

  // The worst integer used here is the largest 31-bit prime, which on its own
  // costs the full search. The random integers are kept small or smooth so
  // that each stays far cheaper. The watchdog allows several times the length
  // of a correct run.
  localparam longint LIMIT_TIME   = 80_000_000;
  localparam int     DRAIN_CYCLES = 40;
  localparam int     NUM_RANDOM   = 100;
  localparam int     NUM_PRIMES   = 25;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [VALUE_BITS-1:0] in_value;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PRIME_W-1:0]    out_factor_prime;
  logic [EXP_W-1:0]      out_exponent;
  logic [STATUS_W-1:0]   out_status;
  logic                  out_last;
  int                    mismatches;
  int                    pending;

  // Primes used to build smooth integers with random content.
  int small_primes [0:NUM_PRIMES-1] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                        43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

  // Directed integers. Zero and one take their own status paths. Small
  // values such as 15 leave a prime cofactor for the closing step, whereas
  // 961 is a prime square, so the search must stop exactly at its root.
  // 2^30 gives the largest exponent of two, 3^19 the largest exponent of an
  // odd prime, and 223092870 is the product of the first nine primes, which
  // is the most distinct factors that a 31-bit integer can hold. 2^30 - 1 and
  // 2^31 - 2 together set every input bit, and 2^31 - 1 is the largest input
  // of all and a prime, so it exercises the full search and the widest
  // factor_prime.
  logic [VALUE_BITS-1:0] corner_values [0:16] = '{
    31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd6, 31'd9, 31'd15, 31'd961, 31'd1024,
    31'd65521, 31'd223092870, 31'd1162261467, 31'd1073741824, 31'd1073741823,
    31'd2147483646, 31'd2147483647
  };

  int stall_left = 0;
  int go_left    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  trial_division_factorizer #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_factor_prime (out_factor_prime),
    .out_exponent     (out_exponent),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  tdf_factor_checker #(
    .VALUE_BITS(VALUE_BITS)
  ) factor_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_factor_prime (out_factor_prime),
    .out_exponent     (out_exponent),
    .out_status       (out_status),
    .out_last         (out_last),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  // Idle length in cycles: usually none, often a few, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 150);
  endfunction

  // The receiver alternates stalls and open windows of random length. Now and
  // then it opens up for a long calm stretch, so that results also flow back to
  // back. The block keeps a result in its output register and one more in the
  // staging register, so stalls here land on every stage of the search.
  always @(posedge clk) begin
    if (stall_left == 0 && go_left == 0) begin
      if ($urandom_range(0, 19) == 0) begin
        go_left = $urandom_range(100, 400);
      end else begin
        stall_left = pick_gap();
        go_left    = $urandom_range(1, 6);
      end
    end
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      go_left   = go_left - 1;
    end
  end

  // Offers one integer and returns at the edge where the transaction is
  // taken. Valid is only dropped when a gap really follows, so a back-to-back
  // transaction never sees valid lowered and raised in the same step.
  task automatic send_value(input logic [VALUE_BITS-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin : stimulus
    longint unsigned       acc;
    int                    prime;
    int                    mode;
    int                    k;
    logic [VALUE_BITS-1:0] value;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_value <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (corner_values[i]) begin
      send_value(corner_values[i]);
    end

    // Random integers. Their cost grows with the square root of the largest
    // cofactor, so every kind here keeps that cofactor small. Smooth
    // products reach high exponents and many distinct primes. Small uniform
    // values give a wide mix of primes and composites. Random high bits over
    // a run of zeros set every upper input bit while leaving a cofactor of
    // at most 17 bits. A few tiny values revisit zero and one.
    repeat (NUM_RANDOM) begin
      mode = $urandom_range(0, 99);
      if (mode < 40) begin
        acc = 1;
        repeat ($urandom_range(1, 6)) begin
          prime = small_primes[$urandom_range(0, NUM_PRIMES - 1)];
          repeat ($urandom_range(1, 5)) begin
            if (acc * prime < (64'd1 << VALUE_BITS)) acc = acc * prime;
          end
        end
        value = acc[VALUE_BITS-1:0];
      end else if (mode < 70) begin
        value = VALUE_BITS'($urandom_range(2, 65535));
      end else if (mode < 90) begin
        k     = $urandom_range(14, 24);
        value = VALUE_BITS'($urandom() & ~((32'd1 << k) - 32'd1));
      end else begin
        value = VALUE_BITS'($urandom_range(0, 15));
      end
      send_value(value);
    end
    in_valid <= 1'b0;

    // The checker's count of outstanding results is a registered copy, so the
    // first sample is taken on the edge after the final transaction.
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_TIME);
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
